// ===== rtl/core/assert_macros.svh =====
// assertion helpers used by the splitter core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, switched off during reset
`define ASSERT_IMPLY(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");

// next-cycle implication, switched off during reset
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/awrs_pkg.sv =====
package awrs_pkg;

  // field widths of the words on each side
  localparam int SizeWidth  = 16;
  localparam int RangeWidth = SizeWidth + 1;
  localparam int CntWidth   = 4;
  localparam int IdxWidth   = 3;
  localparam int AlignWidth = 3;

  // most workers one split may use
  localparam logic [CntWidth-1:0] MaxWorkers = 4'd8;

  // reset value of the alignment register
  localparam logic [AlignWidth-1:0] AlignLog2Reset = 3'd2;

  typedef struct packed {
    logic [CntWidth-1:0]  thread_count;
    logic [SizeWidth-1:0] total_size;
  } in_t;

  typedef struct packed {
    logic [IdxWidth-1:0]   worker_index;
    logic [RangeWidth-1:0] range_start;
    logic [RangeWidth-1:0] range_end;
    logic [CntWidth-1:0]   threads_used;
    logic                  last_range;
  } out_t;

endpackage

// ===== rtl/core/aligned_work_range_splitter_core.sv =====
// Splits [0, total_size) into up to eight aligned contiguous ranges. A word is taken when
// start is high and busy is low; unless the split uses no worker, busy then stays high and
// falls in the cycle in which the last range word is on the ports. Range words come out one
// per worker on out_valid, each for one cycle, and cannot be held off. A split that uses no
// worker answers with a single word in the cycle after acceptance and never raises busy.
// Otherwise each worker passes a setup state, 17 steps of the shared one-bit-per-cycle
// restoring divider forming the ceiling share, and a state that aligns the next start
// and sends the word. The alignment register may be written only while busy is low.
`include "assert_macros.svh"

module aligned_work_range_splitter_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  awrs_pkg::in_t                       in_data,
  output logic                                out_valid,
  output awrs_pkg::out_t                      out_data,
  input  logic                                cfg_we,
  input  logic [awrs_pkg::AlignWidth-1:0]     cfg_wdata
);

  localparam int SW  = awrs_pkg::SizeWidth;
  localparam int RW  = awrs_pkg::RangeWidth;
  localparam int CW  = awrs_pkg::CntWidth;
  localparam int IW  = awrs_pkg::IdxWidth;
  localparam int NW  = SW + 1;
  localparam int SCW = $clog2(NW + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SETUP = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_NEXT  = 2'd3;

  logic [1:0]                      state_r, state_nxt;
  logic [awrs_pkg::AlignWidth-1:0] align_r;
  logic [SW-1:0]                   total_r, total_nxt;
  logic [SW-1:0]                   rem_r, rem_nxt;
  logic [CW-1:0]                   used_r, used_nxt;
  logic [IW-1:0]                   idx_r, idx_nxt;
  logic [RW-1:0]                   cur_start_r, cur_start_nxt;
  logic [CW-1:0]                   den_r, den_nxt;
  logic [NW-1:0]                   num_r, num_nxt;
  logic [CW-1:0]                   part_r, part_nxt;
  logic [SCW-1:0]                  step_r, step_nxt;
  logic                            out_valid_r, out_valid_nxt;
  awrs_pkg::out_t                  out_data_r, out_data_nxt;

  logic                            accept_w;
  logic [7:0]                      align_w;
  logic [6:0]                      amask_w;
  logic [7:0]                      quarter_w;
  logic [CW-1:0]                   req_cap_w;
  logic [RW-1:0]                   needed_w;
  logic [CW-1:0]                   used_w;
  logic [CW:0]                     trial_w;
  logic                            qbit_w;
  logic [SW-1:0]                   share_w;
  logic [SW-1:0]                   rem_new_w;
  logic [SW-1:0]                   raw_next_w;
  logic [6:0]                      low_w;
  logic [RW-1:0]                   aligned_w;
  logic                            more_w;
  logic                            empty_take_w;
  logic                            empty_word_w;
  logic                            used_word_w;
  logic                            idx_ok_w;

  assign accept_w = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // alignment mask and quarter threshold
  assign align_w   = 8'd1 << align_r;
  assign amask_w   = 7'(align_w - 8'd1);
  assign quarter_w = align_w >> 2;

  // worker cap: requested count, saturated, then limited by aligned blocks
  assign req_cap_w = (in_data.thread_count > awrs_pkg::MaxWorkers) ?
                     awrs_pkg::MaxWorkers : in_data.thread_count;
  assign needed_w  = ({1'b0, in_data.total_size} + {10'd0, amask_w}) >> align_r;
  assign used_w    = ({13'd0, req_cap_w} > needed_w) ? needed_w[CW-1:0] : req_cap_w;

  // one restoring divider step
  assign trial_w = {part_r, num_r[NW-1]};
  assign qbit_w  = (trial_w >= {1'b0, den_r});

  // share, what is left, and the next start before alignment
  assign share_w    = num_r[SW-1:0];
  assign rem_new_w  = rem_r - share_w;
  assign raw_next_w = total_r - rem_new_w;
  assign more_w     = ({1'b0, idx_r} + 4'd1) < used_r;

  // round the next start up past a quarter block, else down
  assign low_w = raw_next_w[6:0] & amask_w;
  always_comb begin
    if ({1'b0, low_w} > quarter_w) begin
      aligned_w = ({1'b0, raw_next_w} + {10'd0, amask_w}) & ~{10'd0, amask_w};
    end else begin
      aligned_w = {1'b0, raw_next_w} & ~{10'd0, amask_w};
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    total_nxt     = total_r;
    rem_nxt       = rem_r;
    used_nxt      = used_r;
    idx_nxt       = idx_r;
    cur_start_nxt = cur_start_r;
    den_nxt       = den_r;
    num_nxt       = num_r;
    part_nxt      = part_r;
    step_nxt      = step_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept_w) begin
          total_nxt     = in_data.total_size;
          rem_nxt       = in_data.total_size;
          used_nxt      = used_w;
          idx_nxt       = '0;
          cur_start_nxt = '0;
          if (used_w == '0) begin
            out_valid_nxt             = 1'b1;
            out_data_nxt.worker_index = '0;
            out_data_nxt.range_start  = '0;
            out_data_nxt.range_end    = '0;
            out_data_nxt.threads_used = '0;
            out_data_nxt.last_range   = 1'b1;
          end else begin
            state_nxt = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        den_nxt   = used_r - {1'b0, idx_r};
        num_nxt   = {1'b0, rem_r} + {13'd0, den_nxt} - 17'd1;
        part_nxt  = '0;
        step_nxt  = SCW'(NW - 1);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        part_nxt = qbit_w ? CW'(trial_w - {1'b0, den_r}) : trial_w[CW-1:0];
        num_nxt  = {num_r[NW-2:0], qbit_w};
        step_nxt = step_r - SCW'(1);
        if (step_r == '0) begin
          state_nxt = ST_NEXT;
        end
      end
      ST_NEXT: begin
        out_valid_nxt             = 1'b1;
        out_data_nxt.worker_index = idx_r;
        out_data_nxt.range_start  = cur_start_r;
        out_data_nxt.threads_used = used_r;
        if (more_w) begin
          out_data_nxt.range_end  = aligned_w;
          out_data_nxt.last_range = 1'b0;
          cur_start_nxt           = aligned_w;
          rem_nxt                 = rem_new_w;
          idx_nxt                 = idx_r + IW'(1);
          state_nxt               = ST_SETUP;
        end else begin
          out_data_nxt.range_end  = {1'b0, total_r};
          out_data_nxt.last_range = 1'b1;
          state_nxt               = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      align_r     <= awrs_pkg::AlignLog2Reset;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        align_r <= cfg_wdata;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    total_r     <= total_nxt;
    rem_r       <= rem_nxt;
    used_r      <= used_nxt;
    idx_r       <= idx_nxt;
    cur_start_r <= cur_start_nxt;
    den_r       <= den_nxt;
    num_r       <= num_nxt;
    part_r      <= part_nxt;
    step_r      <= step_nxt;
    out_data_r  <= out_data_nxt;
  end

  // terms for the checks
  assign empty_take_w = accept_w && (used_w == '0);
  assign empty_word_w = out_valid && out_data.last_range && (out_data.threads_used == '0);
  assign used_word_w  = out_valid && (out_data.threads_used != '0);
  assign idx_ok_w     = {1'b0, out_data.worker_index} < out_data.threads_used;

  // checks
  `ASSERT_NEXT(a_more_keeps_busy, clk, rst_n, out_valid && !out_data.last_range, busy)
  `ASSERT_IMPLY(a_last_frees, clk, rst_n, out_valid && out_data.last_range, !busy)
  `ASSERT_NEXT(a_empty_split, clk, rst_n, empty_take_w, empty_word_w)
  `ASSERT_IMPLY(a_index_in_range, clk, rst_n, used_word_w, idx_ok_w)

endmodule

// ===== test/aligned_work_range_splitter_core_test.sv =====
`timescale 1ns / 1ps

module aligned_work_range_splitter_core_test;

  localparam int AW = awrs_pkg::AlignWidth;
  localparam int SW = awrs_pkg::SizeWidth;
  localparam int RW = awrs_pkg::RangeWidth;
  localparam int CW = awrs_pkg::CntWidth;
  localparam int IW = awrs_pkg::IdxWidth;

  // rows of the directed part, with a typed-in answer where one is obvious
  typedef struct {
    logic [AW-1:0]  align;
    awrs_pkg::in_t  word;
    bit             typed;
    awrs_pkg::out_t want;
  } plan_row_t;

  logic           clk = 1'b0;
  logic           rst_n;
  logic           start;
  logic           busy;
  awrs_pkg::in_t  in_data;
  logic           out_valid;
  awrs_pkg::out_t out_data;
  logic           cfg_we;
  logic [AW-1:0]  cfg_wdata;

  // shadow of the alignment register and the range words still to come
  logic [AW-1:0]  align_shift;
  awrs_pkg::out_t ranges_due[$];
  plan_row_t      directed_plan[$];
  int unsigned    idle_pct;
  int unsigned    splits_sent;
  int unsigned    words_seen;
  int unsigned    mismatches;

  aligned_work_range_splitter_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // works out the range words one split should produce
  function automatic void predict_split(input awrs_pkg::in_t word);
    int unsigned    req, total, align, amask, needed, used, remaining, share, s, i;
    int unsigned    lo[8];
    int unsigned    hi[8];
    awrs_pkg::out_t r;
    req = word.thread_count;
    if (req > awrs_pkg::MaxWorkers) req = awrs_pkg::MaxWorkers;
    total = word.total_size;
    align = 1 << align_shift;
    amask = align - 1;
    needed = (total + amask) / align;
    used = (req < needed) ? req : needed;
    if (used == 0) begin
      r = '0;
      r.last_range = 1'b1;
      ranges_due.push_back(r);
    end else begin
      // ceiling share of what is left, worker by worker
      remaining = total;
      lo[0] = 0;
      for (i = 0; i < used; i++) begin
        share = (remaining + (used - i) - 1) / (used - i);
        remaining -= share;
        hi[i] = lo[i] + share;
        if (i + 1 < used) lo[i + 1] = hi[i];
      end
      // snap later starts to the alignment, previous end follows
      for (i = 1; i < used; i++) begin
        s = lo[i];
        if ((s & amask) > (align >> 2)) s = (s + amask) & ~amask;
        else s = s & ~amask;
        lo[i] = s;
        hi[i - 1] = s;
      end
      for (i = 0; i < used; i++) begin
        r.worker_index = IW'(i);
        r.range_start  = RW'(lo[i]);
        r.range_end    = RW'(hi[i]);
        r.threads_used = CW'(used);
        r.last_range   = (i + 1 == used);
        ranges_due.push_back(r);
      end
    end
  endfunction

  function automatic void add_row(input int align, input int threads, input int total,
                                  input bit typed, input int lo, input int hi,
                                  input int used);
    plan_row_t row;
    row.align              = AW'(align);
    row.word.thread_count  = CW'(threads);
    row.word.total_size    = SW'(total);
    row.typed              = typed;
    row.want.worker_index  = '0;
    row.want.range_start   = RW'(lo);
    row.want.range_end     = RW'(hi);
    row.want.threads_used  = CW'(used);
    row.want.last_range    = 1'b1;
    directed_plan.push_back(row);
  endfunction

  // random split request, mostly sizes near the alignment scale
  function automatic awrs_pkg::in_t random_word();
    awrs_pkg::in_t word;
    int unsigned   pick, align, total;
    align = 1 << align_shift;
    if ($urandom_range(9) == 0) word.thread_count = CW'($urandom_range(15));
    else word.thread_count = CW'($urandom_range(1, 8));
    pick = $urandom_range(99);
    if (pick < 5) total = $urandom_range(1);
    else if (pick < 45) total = $urandom_range(1, align * 12);
    else if (pick < 80) total = $urandom_range(65535);
    else if (pick < 95) total = align * $urandom_range(1, 40) + $urandom_range(align / 2 + 1);
    else total = 65535 - $urandom_range(3);
    if (total > 65535) total = 65535;
    word.total_size = SW'(total);
    return word;
  endfunction

  // offer one word, dropping start at random, until it is taken
  task automatic offer_word(input awrs_pkg::in_t word);
    bit taken;
    in_data <= word;
    taken = 1'b0;
    while (!taken) begin
      start <= ($urandom_range(99) >= idle_pct);
      @(posedge clk);
      taken = start && !busy;
    end
    splits_sent++;
  endtask

  // let the block run dry before touching the register
  task automatic settle();
    start <= 1'b0;
    while (ranges_due.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_align(input logic [AW-1:0] value);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    align_shift = value;
    cfg_we    <= 1'b0;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("range word %0d: %s expected %0d, got %0d", words_seen, name, want, got);
    end
  endtask

  // compare every range word with the oldest one due
  always @(posedge clk) begin
    awrs_pkg::out_t want;
    if (rst_n && out_valid) begin
      if (ranges_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("range word %0d arrived with nothing due: worker %0d, %0d to %0d",
                   words_seen, out_data.worker_index, out_data.range_start,
                   out_data.range_end);
      end else begin
        want = ranges_due.pop_front();
        check_field("worker_index", want.worker_index, out_data.worker_index);
        check_field("range_start", want.range_start, out_data.range_start);
        check_field("range_end", want.range_end, out_data.range_end);
        check_field("threads_used", want.threads_used, out_data.threads_used);
        check_field("last_range", want.last_range, out_data.last_range);
      end
      words_seen++;
    end
  end

  // stimulus
  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_data     = '0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    align_shift = awrs_pkg::AlignLog2Reset;
    idle_pct    = 7;
    splits_sent = 0;
    words_seen  = 0;
    mismatches  = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // nothing to split, single workers, saturation and capping at reset alignment
    add_row(2, 0, 100, 1, 0, 0, 0);
    add_row(2, 5, 0, 1, 0, 0, 0);
    add_row(2, 0, 0, 1, 0, 0, 0);
    add_row(2, 15, 0, 1, 0, 0, 0);
    add_row(2, 1, 65535, 1, 0, 65535, 1);
    add_row(2, 1, 1, 1, 0, 1, 1);
    add_row(2, 15, 65535, 0, 0, 0, 0);
    add_row(2, 8, 65535, 0, 0, 0, 0);
    add_row(2, 9, 1000, 0, 0, 0, 0);
    add_row(2, 8, 5, 0, 0, 0, 0);
    add_row(2, 3, 10, 0, 0, 0, 0);
    add_row(2, 4, 13, 0, 0, 0, 0);
    add_row(2, 7, 7, 0, 0, 0, 0);
    // alignment of one item
    add_row(0, 8, 3, 0, 0, 0, 0);
    add_row(0, 8, 65535, 0, 0, 0, 0);
    add_row(0, 2, 1, 1, 0, 1, 1);
    // register at seven and six, starts may be pushed past their end
    add_row(7, 8, 65535, 0, 0, 0, 0);
    add_row(7, 2, 130, 0, 0, 0, 0);
    add_row(7, 8, 128, 1, 0, 128, 1);
    add_row(7, 3, 129, 0, 0, 0, 0);
    add_row(7, 8, 5, 0, 0, 0, 0);
    add_row(6, 8, 1000, 0, 0, 0, 0);
    add_row(6, 3, 64, 1, 0, 64, 1);
    add_row(6, 2, 65, 0, 0, 0, 0);

    foreach (directed_plan[k]) begin
      if (directed_plan[k].align != align_shift) begin
        settle();
        write_align(directed_plan[k].align);
      end
      offer_word(directed_plan[k].word);
      if (directed_plan[k].typed) ranges_due.push_back(directed_plan[k].want);
      else predict_split(directed_plan[k].word);
    end
    settle();

    // random blocks, each at its own alignment, sender idling 7, then 50, then 0 percent of the time
    for (int blk = 0; blk < 8; blk++) begin
      idle_pct = (blk < 3) ? 7 : (blk < 6) ? 50 : 0;
      write_align(AW'(blk * 3));
      repeat (40) begin
        awrs_pkg::in_t word;
        word = random_word();
        offer_word(word);
        predict_split(word);
      end
      settle();
    end

    repeat (20) @(posedge clk);
    if (ranges_due.size() != 0) mismatches++;
    $display("%0d splits sent over all eight alignments, %0d range words compared",
             splits_sent, words_seen);
    if (mismatches == 0) begin
      $display("aligned_work_range_splitter_core test passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("aligned_work_range_splitter_core test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("aligned_work_range_splitter_core test failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/awrs_pkg.sv
rtl/core/aligned_work_range_splitter_core.sv
test/aligned_work_range_splitter_core_test.sv
